### src/lcm_pkg.sv
// shared constants and types for the line command matcher
package lcm_pkg;

  typedef logic [7:0] byte_t;

  // line buffer depth, counter holds 0 to LINE_DEPTH-1
  localparam int LINE_DEPTH = 32;
  localparam int LEN_W      = $clog2(LINE_DEPTH);

  localparam byte_t BYTE_PROG    = 8'h7F;
  localparam byte_t BYTE_NEWLINE = 8'h0A;

  localparam int CMD_COUNT   = 6;
  localparam int CMD_MAX_LEN = 8;
  localparam int CMD_IDX_W   = $clog2(CMD_MAX_LEN);
  localparam int CMD_LEN_W   = $clog2(CMD_MAX_LEN + 1);

  typedef enum logic [2:0] {
    EV_NONE,
    EV_STOP,
    EV_START,
    EV_AGC_ON,
    EV_AGC_OFF,
    EV_ACQUIRE,
    EV_RESTART
  } event_t;

  localparam byte_t CMD_TEXT [CMD_COUNT][CMD_MAX_LEN] = '{
    '{"A", "S", "T", "O", "P", "Z", 8'h00, 8'h00},
    '{"A", "S", "T", "A", "R", "T", "Z", 8'h00},
    '{"A", "A", "G", "C", "O", "N", "Z", 8'h00},
    '{"A", "A", "G", "C", "O", "F", "F", "Z"},
    '{"A", "A", "C", "Q", "Z", 8'h00, 8'h00, 8'h00},
    '{"A", "R", "E", "S", "E", "T", "Z", 8'h00}
  };

  localparam logic [CMD_LEN_W-1:0] CMD_LEN [CMD_COUNT] = '{
    CMD_LEN_W'(6), CMD_LEN_W'(7), CMD_LEN_W'(7),
    CMD_LEN_W'(8), CMD_LEN_W'(5), CMD_LEN_W'(7)
  };

  localparam event_t EVENT_CODE [CMD_COUNT] = '{
    EV_STOP, EV_START, EV_AGC_ON, EV_AGC_OFF, EV_ACQUIRE, EV_RESTART
  };

endpackage

### src/line_command_matcher.sv
// line command matcher: collects serial bytes into a line and decodes commands
//
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per beat.
// Output channel: out_valid / out_stall carry one result beat per input beat:
//   event_res (0 none, 1 stop, 2 start, 3 agc on, 4 agc off, 5 acquire,
//   6 restart), line_end (the byte was a newline) and program_mode (sticky
//   flag, set once 0x7F has been seen).
// The result beat is registered: a byte accepted in one cycle shows its result
// beat in the next. Throughput is one byte per cycle while the receiver does not
// stall; the line is matched on the fly with one prefix flag per command, so the
// per-byte work is a single byte compare per command and a length check.
// When the receiver stalls, the result register holds its beat and in_stall
// rises in the same cycle, so no byte is taken until the beat leaves; a new
// byte is accepted in the cycle the waiting beat is taken.
// Reset empties the line, sets every prefix flag, clears the programming flag and
// the output valid; the block is ready for a byte in the first cycle after reset.
module line_command_matcher (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcm_pkg::byte_t      rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          event_res,
  output logic                line_end,
  output logic                program_mode
);
  import lcm_pkg::*;

  logic                 in_accept;
  logic [LEN_W-1:0]     line_length;
  logic [LEN_W-1:0]     line_length_next;
  logic [CMD_COUNT-1:0] prefix_ok;
  logic [CMD_COUNT-1:0] prefix_ok_next;
  logic [CMD_COUNT-1:0] prefix_hit;
  logic                 prog_flag;
  logic                 prog_flag_next;
  event_t               event_q;
  event_t               event_next;
  logic                 line_end_next;

  assign in_stall     = out_valid && out_stall;
  assign in_accept    = in_valid && !in_stall;
  assign event_res    = event_q;
  assign program_mode = prog_flag;

  // byte matches the command character at the current position
  always_comb begin
    for (int c = 0; c < CMD_COUNT; c++) begin
      prefix_hit[c] = (line_length < LEN_W'(CMD_LEN[c])) &&
                      (rx_byte == CMD_TEXT[c][line_length[CMD_IDX_W-1:0]]);
    end
  end

  always_comb begin
    line_length_next = line_length;
    prefix_ok_next   = prefix_ok;
    prog_flag_next   = prog_flag;
    event_next       = EV_NONE;
    line_end_next    = 1'b0;
    if (rx_byte == BYTE_PROG) begin
      prog_flag_next = 1'b1;
    end else if (rx_byte == BYTE_NEWLINE) begin
      line_end_next = 1'b1;
      // descending so the first command in the list wins
      for (int c = CMD_COUNT - 1; c >= 0; c--) begin
        if (prefix_ok[c] && (line_length == LEN_W'(CMD_LEN[c]))) begin
          event_next = EVENT_CODE[c];
        end
      end
      line_length_next = '0;
      prefix_ok_next   = '1;
    end else if (line_length < LEN_W'(LINE_DEPTH - 1)) begin
      line_length_next = line_length + LEN_W'(1);
      prefix_ok_next   = prefix_ok & prefix_hit;
    end else begin
      // overflow: drop byte and restart the line
      line_length_next = '0;
      prefix_ok_next   = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      prefix_ok   <= '1;
      prog_flag   <= 1'b0;
      out_valid   <= 1'b0;
      event_q     <= EV_NONE;
      line_end    <= 1'b0;
    end else begin
      if (in_accept) begin
        line_length <= line_length_next;
        prefix_ok   <= prefix_ok_next;
        prog_flag   <= prog_flag_next;
        event_q     <= event_next;
        line_end    <= line_end_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/lcm_checker.sv
// port-level checks for the line command matcher, bound into the matcher module
module lcm_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input lcm_pkg::byte_t rx_byte,
  input logic           out_valid,
  input logic           out_stall,
  input logic [2:0]     event_res,
  input logic           line_end,
  input logic           program_mode
);
  import lcm_pkg::*;

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) &&
    $stable(line_end) && $stable(program_mode))
    else $error("result beat changed while stalled");

  // an event only comes with a line end
  a_event_needs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_end |-> event_res == EV_NONE)
    else $error("event without line end");

  // programming mode never clears once set
  a_prog_sticky: assert property (@(posedge clk) disable iff (rst)
    program_mode |=> program_mode)
    else $error("program mode cleared");

  // a programming byte sets the flag in its own result beat
  a_prog_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && rx_byte == BYTE_PROG |=>
    out_valid && program_mode && !line_end)
    else $error("programming byte not reflected");

  // line end follows exactly from a newline byte
  a_newline: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid && (line_end == $past(rx_byte == BYTE_NEWLINE)))
    else $error("line end does not match newline");

endmodule

bind line_command_matcher lcm_port_checker u_lcm_port_checker (.*);

### test/lcm_checker.sv
// checker for the line command matcher: predicts each result beat and compares it
`timescale 1ns / 1ps

module lcm_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  lcm_pkg::byte_t rx_byte,
  input  logic           out_valid,
  input  logic           out_stall,
  input  logic [2:0]     event_res,
  input  logic           line_end,
  input  logic           program_mode,
  output int             errors,
  output int             waiting,
  output int             lines_seen,
  output int             cmds_seen
);

  import lcm_pkg::*;

  typedef struct packed {
    event_t ev;
    logic   eol;
    logic   pmode;
  } beat_t;

  // shadow copy of the line buffer and flags
  byte_t line_buf [LINE_DEPTH];
  int    line_len;
  logic  prog_seen;
  beat_t beat_q [$];

  function automatic event_t match_line();
    event_t hit;
    bit     same;
    hit = EV_NONE;
    for (int c = 0; c < CMD_COUNT; c++) begin
      if (line_len == int'(CMD_LEN[c])) begin
        same = 1'b1;
        for (int i = 0; i < int'(CMD_LEN[c]); i++)
          if (line_buf[i] != CMD_TEXT[c][i]) same = 1'b0;
        if (same && hit == EV_NONE) hit = EVENT_CODE[c];
      end
    end
    return hit;
  endfunction

  function automatic beat_t decode_byte(byte_t b);
    beat_t r;
    r.ev  = EV_NONE;
    r.eol = 1'b0;
    if (b == BYTE_PROG) begin
      prog_seen = 1'b1;
    end else if (b == BYTE_NEWLINE) begin
      r.ev     = match_line();
      r.eol    = 1'b1;
      line_len = 0;
    end else if (line_len < LINE_DEPTH - 1) begin
      line_buf[line_len] = b;
      line_len++;
    end else begin
      // full line: byte dropped, line starts over
      line_len = 0;
    end
    r.pmode = prog_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    beat_t want;
    int    nerr;
    nerr = 0;
    if (rst) begin
      line_len  = 0;
      prog_seen = 1'b0;
      beat_q.delete();
      errors     <= 0;
      waiting    <= 0;
      lines_seen <= 0;
      cmds_seen  <= 0;
    end else begin
      // a result beat always belongs to an earlier byte, so pop before push
      if (out_valid && !out_stall) begin
        if (beat_q.size() == 0) begin
          $error("result beat arrived with nothing pending");
          nerr++;
        end else begin
          want = beat_q.pop_front();
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, actual %0d", want.ev, event_res);
            nerr++;
          end
          if (line_end !== want.eol) begin
            $error("line_end: expected %0d, actual %0d", want.eol, line_end);
            nerr++;
          end
          if (program_mode !== want.pmode) begin
            $error("program_mode: expected %0d, actual %0d", want.pmode, program_mode);
            nerr++;
          end
        end
        if (line_end === 1'b1) lines_seen <= lines_seen + 1;
        if (line_end === 1'b1 && event_res != EV_NONE) cmds_seen <= cmds_seen + 1;
      end
      if (in_valid && !in_stall) beat_q.push_back(decode_byte(rx_byte));
      errors  <= errors + nerr;
      waiting <= beat_q.size();
    end
  end

endmodule

### test/tb.sv
// testbench top for the line command matcher: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tb;

  import lcm_pkg::*;

  localparam int    DIRECTED_ITEMS = 25;
  localparam int    RANDOM_ITEMS   = 700;
  localparam int    HOLD_CYCLES    = 80;
  localparam int    IDLE_LIMIT     = 2000;
  localparam byte_t BYTE_CR        = 8'h0D;

  typedef enum int {
    FLAW_NONE,
    FLAW_CHAR,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_PROG,
    FLAW_CR
  } flaw_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  byte_t      rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] event_res;
  logic       line_end;
  logic       program_mode;

  int errors;
  int waiting;
  int lines_seen;
  int cmds_seen;
  int n_sent;
  bit calm;
  bit hold_req;

  line_command_matcher u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .line_end     (line_end),
    .program_mode (program_mode)
  );

  lcm_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .line_end     (line_end),
    .program_mode (program_mode),
    .errors       (errors),
    .waiting      (waiting),
    .lines_seen   (lines_seen),
    .cmds_seen    (cmds_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic byte_t plain_byte();
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    if (b == BYTE_NEWLINE || b == BYTE_PROG) b = b ^ 8'h20;
    return b;
  endfunction

  task automatic send_byte(input byte_t b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_command(input event_t ev, input flaw_t flaw);
    int    c;
    int    pos;
    byte_t ch;
    c   = int'(ev) - 1;
    pos = $urandom_range(0, int'(CMD_LEN[c]) - 1);
    for (int i = 0; i < int'(CMD_LEN[c]); i++) begin
      ch = CMD_TEXT[c][i];
      if (flaw == FLAW_CHAR && i == pos) ch = byte_t'($urandom_range(0, 255));
      if (flaw == FLAW_PROG && i == pos) send_byte(BYTE_PROG);
      if (!(flaw == FLAW_SHORT && i == int'(CMD_LEN[c]) - 1)) send_byte(ch);
    end
    if (flaw == FLAW_LONG) send_byte(plain_byte());
    if (flaw == FLAW_CR) send_byte(BYTE_CR);
    send_byte(BYTE_NEWLINE);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    int  pick;
    bit  hold_done;
    bit  paused;
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    n_sent    = 0;
    hold_done = 1'b0;
    paused    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty line, zero and all-ones bytes, cr lf ending, clean and split commands
    send_byte(BYTE_NEWLINE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_NEWLINE);
    send_command(EV_STOP, FLAW_CR);
    send_command(EV_ACQUIRE, FLAW_NONE);
    send_command(EV_ACQUIRE, FLAW_PROG);
    wait_drained();

    while (n_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (!hold_done && n_sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!paused && n_sent >= 500) begin
        wait_drained();
        paused = 1'b1;
      end
      calm = (n_sent >= 600);
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4, 5: begin
          send_command(event_t'($urandom_range(1, CMD_COUNT)),
                       ($urandom_range(0, 2) == 0) ? flaw_t'($urandom_range(1, 5))
                                                   : FLAW_NONE);
        end
        6: begin
          send_command(event_t'($urandom_range(1, CMD_COUNT)),
                       flaw_t'($urandom_range(1, 5)));
        end
        7: begin
          // fill to the edge of the buffer; a restart can leave a clean command behind
          repeat ($urandom_range(LINE_DEPTH - 3, LINE_DEPTH + 2)) send_byte(plain_byte());
          if ($urandom_range(0, 1) == 1)
            send_command(event_t'($urandom_range(1, CMD_COUNT)), FLAW_NONE);
          else
            send_byte(BYTE_NEWLINE);
        end
        8: begin
          repeat ($urandom_range(0, 12)) send_byte(byte_t'($urandom_range(0, 255)));
          send_byte(BYTE_NEWLINE);
        end
        default: begin
          // broken fragment, no newline
          repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom_range(0, 255)));
        end
      endcase
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("sent %0d bytes; %0d lines closed, %0d matched a command",
             n_sent, lines_seen, cmds_seen);
    $display("mix of clean and flawed commands, overflow restarts, noise, long hold, drains");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
